/* hdl/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared widths, types and constants of the lru key-value cache
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t MISS_VALUE = '1;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t command;
    key_t lookup_key;
    val_t write_value;
  } req_t;

  typedef struct packed {
    logic hit;
    val_t read_value;
  } rsp_t;

endpackage

`default_nettype wire

/* hdl/lkvc_ifs.sv */
// ----------------------------------------------------------------------------
// lkvc channel interfaces
// valid/ready channels for request words, result words and the capacity write
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_in_if;
  import lkvc_pkg::*;
  logic valid;
  logic ready;
  cmd_t command;
  key_t lookup_key;
  val_t write_value;
  modport source (output valid, command, lookup_key, write_value, input ready);
  modport sink   (input valid, command, lookup_key, write_value, output ready);
endinterface

interface lkvc_out_if;
  import lkvc_pkg::*;
  logic valid;
  logic ready;
  logic hit;
  val_t read_value;
  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

interface lkvc_cfg_if;
  import lkvc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] active_capacity;
  modport source (output valid, active_capacity, input ready);
  modport sink   (input valid, active_capacity, output ready);
endinterface

`default_nettype wire

/* hdl/lkvc_store.sv */
// ----------------------------------------------------------------------------
// lkvc_store
// recency-ordered entry store: parallel key match, one-pass shift to front
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  lkvc_pkg::req_t               req,
  input  logic [lkvc_pkg::CAP_W-1:0]   cap,
  output lkvc_pkg::rsp_t               rsp
);
  import lkvc_pkg::*;

  key_t             keys_r [ENTRIES];
  val_t             vals_r [ENTRIES];
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;

  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] match;
  logic               found;
  logic [IDX_W-1:0]   found_idx;
  logic [CMP_W-1:0]   cap_ext;
  logic [CNT_W-1:0]   cap_eff;
  logic               full;
  logic [CNT_W-1:0]   upto;
  logic               wr_en;
  val_t               new_val;

  // entries 0..fill-1 are valid, entry 0 most recent
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid[i] = CNT_W'(i) < fill_r;
      match[i] = valid[i] && (keys_r[i] == req.lookup_key);
    end
    found     = |match;
    found_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_idx = IDX_W'(i);
      end
    end
  end

  // capacity saturates to 1..ENTRIES
  always_comb begin
    cap_ext = CMP_W'(cap);
    if (cap_ext == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_ext);
    end
  end

  always_comb begin
    full    = (fill_r >= cap_eff) && (fill_r != '0);
    wr_en   = found || (req.command == CMD_PUT);
    new_val = (req.command == CMD_PUT) ? req.write_value : vals_r[found_idx];
    if (found) begin
      upto     = CNT_W'(found_idx);
      fill_nxt = fill_r;
    end else if (full) begin
      upto     = fill_r - CNT_W'(1);
      fill_nxt = fill_r;
    end else begin
      upto     = fill_r;
      fill_nxt = (req.command == CMD_PUT) ? fill_r + CNT_W'(1) : fill_r;
    end
    rsp.hit        = found;
    rsp.read_value = found ? new_val : MISS_VALUE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (advance) begin
      fill_r <= fill_nxt;
    end
  end

  // shift older entries back by one and write the word at the front
  always_ff @(posedge clk) begin
    if (advance && wr_en) begin
      keys_r[0] <= req.lookup_key;
      vals_r[0] <= new_val;
      for (int i = 1; i < ENTRIES; i++) begin
        if (CNT_W'(i) <= upto) begin
          keys_r[i] <= keys_r[i-1];
          vals_r[i] <= vals_r[i-1];
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/lru_key_value_cache_core.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// fully associative key-value cache with true least-recently-used replacement
// ----------------------------------------------------------------------------
// in_ch takes one request word per ready cycle: get or put, key, put value.
// out_ch returns one result word per request, in order: hit flag and the
// entry value after the operation, or all ones on a miss.
// cfg_ch writes active_capacity (entries in use before eviction starts) and is
// always ready; the user writes it only while the cache is idle, unenforced.
// path: an accepted request is held in the request register, then goes through
// the match-and-shift pass over the 16 entries into the result register once
// that register is free.
// throughput: one request per cycle unless out_ch stalls.
// reset: all entries invalid, capacity 16, both pipeline registers empty.
// stall: when out_ch.ready is low the result word holds, the request
// register holds behind it, and in_ch.ready drops once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_core (
  input  logic        clk,
  input  logic        rst_n,
  lkvc_in_if.sink     in_ch,
  lkvc_out_if.source  out_ch,
  lkvc_cfg_if.sink    cfg_ch
);
  import lkvc_pkg::*;

  logic             s1_valid_r;
  req_t             s1_req_r;
  logic             out_valid_r;
  rsp_t             out_rsp_r;
  logic [CAP_W-1:0] cap_r;
  logic             advance;
  rsp_t             rsp;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_rsp_r.hit;
  assign out_ch.read_value = out_rsp_r.read_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        cap_r <= cfg_ch.active_capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_req_r.command     <= in_ch.command;
      s1_req_r.lookup_key  <= in_ch.lookup_key;
      s1_req_r.write_value <= in_ch.write_value;
    end
    if (advance) begin
      out_rsp_r <= rsp;
    end
  end

  lkvc_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .req     (s1_req_r),
    .cap     (cap_r),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

/* hdl/lkvc_checker.sv */
// ----------------------------------------------------------------------------
// lkvc_checker
// port-level checks of the lru key-value cache, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_hit,
  input logic [lkvc_pkg::VAL_W-1:0]   out_read_value
);
  import lkvc_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_read_value))
    else $error("result word changed while stalled");

  // a miss always reads all ones
  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_read_value == MISS_VALUE)
    else $error("miss without all-ones value");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an accepted word reaches the output once the result register is free
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 (!out_valid || out_ready) |=> out_valid)
    else $error("accepted word did not reach the output");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_hit        (out_ch.hit),
  .out_read_value (out_ch.read_value)
);

`default_nettype wire
